// File: src/mlpq_pkg.sv
// shared types and codes for the multi-level priority queue
// no dependencies; imported by multi_level_priority_queue

package mlpq_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_INVALID = 2'd2;
    localparam status_t ST_EMPTY   = 2'd3;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

endpackage

// File: src/mlpq_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module mlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/multi_level_priority_queue.sv
// multi-level priority queue: one linear queue per level, words kept in one ram
// result registered the cycle after a transfer; a word dequeue loads it in S_READ
// one command per cycle while results are taken; a word dequeue stalls in S_READ
// a result not yet taken holds off the next transfer, ready passes straight through
// reset: all levels empty, pointers zero; ram contents are not cleared
// depends on mlpq_pkg and mlpq_ram

module multi_level_priority_queue #(
    parameter int LEVELS          = 8,
    parameter int SLOTS_PER_LEVEL = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                cmd,
    input  logic [3:0]          priority_req,
    input  logic signed [31:0]  data_in,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mlpq_pkg::status_t   status,
    output logic signed [31:0]  data_out,
    output logic [2:0]          level_out
);

    import mlpq_pkg::*;

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOT_W = $clog2(SLOTS_PER_LEVEL);
    localparam int DEPTH  = LEVELS * SLOTS_PER_LEVEL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_LEVEL - 1);

    state_t state_reg, state_next;

    logic [SLOT_W-1:0] front_reg [LEVELS];
    logic [SLOT_W-1:0] rear_reg  [LEVELS];
    logic [LEVELS-1:0] occ_reg;
    logic [LVL_W-1:0]  pend_lvl_reg;

    logic               rsp_valid_reg;
    status_t            status_reg;
    logic signed [31:0] data_reg;
    logic [2:0]         level_reg;

    logic              accept;
    logic              rsp_free;
    logic              is_deq;
    logic              pri_bad;
    logic              hi_found;
    logic [LVL_W-1:0]  hi_lvl;
    logic [LVL_W-1:0]  enq_lvl;
    logic [LVL_W-1:0]  sel_lvl;
    logic [SLOT_W-1:0] cur_front;
    logic [SLOT_W-1:0] cur_rear;
    logic              cur_occ;

    logic              ptr_we;
    logic [SLOT_W-1:0] front_next;
    logic [SLOT_W-1:0] rear_next;
    logic              occ_next;
    logic [SLOT_W-1:0] acc_slot;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic              ram_re;
    logic [31:0]       ram_rdata;

    logic               load;
    status_t            load_status;
    logic signed [31:0] load_data;
    logic [2:0]         load_level;
    logic               go_read;

    assign accept   = req_valid && req_ready;
    assign rsp_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && rsp_free;
    assign is_deq   = (cmd == CMD_DEQ);
    assign pri_bad  = 32'(priority_req) >= LEVELS;
    assign enq_lvl  = LVL_W'(priority_req);

    // highest occupied level
    always_comb
    begin
        hi_found = 1'b0;
        hi_lvl   = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (occ_reg[i])
            begin
                hi_found = 1'b1;
                hi_lvl   = LVL_W'(i);
            end
        end
    end

    assign sel_lvl   = is_deq ? hi_lvl : enq_lvl;
    assign cur_front = front_reg[sel_lvl];
    assign cur_rear  = rear_reg[sel_lvl];
    assign cur_occ   = occ_reg[sel_lvl];
    assign ram_addr  = ADDR_W'(32'(sel_lvl) * SLOTS_PER_LEVEL + 32'(acc_slot));

    always_comb
    begin
        ptr_we      = 1'b0;
        front_next  = cur_front;
        rear_next   = cur_rear;
        occ_next    = cur_occ;
        acc_slot    = cur_front;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load        = 1'b0;
        load_status = ST_OK;
        load_data   = '0;
        load_level  = '0;
        go_read     = 1'b0;
        if (accept)
        begin
            if (!is_deq)
            begin
                if (pri_bad)
                begin
                    load        = 1'b1;
                    load_status = ST_INVALID;
                end
                else if (!cur_occ)
                begin
                    ptr_we     = 1'b1;
                    front_next = '0;
                    rear_next  = '0;
                    occ_next   = 1'b1;
                    acc_slot   = '0;
                    ram_we     = 1'b1;
                    load       = 1'b1;
                    load_level = 3'(enq_lvl);
                end
                else if (cur_rear == LAST_SLOT)
                begin
                    load        = 1'b1;
                    load_status = ST_FULL;
                    load_level  = 3'(enq_lvl);
                end
                else
                begin
                    ptr_we     = 1'b1;
                    rear_next  = cur_rear + SLOT_W'(1);
                    acc_slot   = cur_rear + SLOT_W'(1);
                    ram_we     = 1'b1;
                    load       = 1'b1;
                    load_level = 3'(enq_lvl);
                end
            end
            else if (!hi_found)
            begin
                load        = 1'b1;
                load_status = ST_EMPTY;
            end
            else
            begin
                ram_re  = 1'b1;
                go_read = 1'b1;
                ptr_we  = 1'b1;
                if (cur_front == cur_rear)
                begin
                    // level drains: pointers go back to the first slot
                    front_next = '0;
                    rear_next  = '0;
                    occ_next   = 1'b0;
                end
                else
                begin
                    front_next = cur_front + SLOT_W'(1);
                end
            end
        end
        else if (state_reg == S_READ && rsp_free)
        begin
            load       = 1'b1;
            load_data  = ram_rdata;
            load_level = 3'(pend_lvl_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            occ_reg       <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                front_reg[i] <= '0;
                rear_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (ptr_we)
            begin
                front_reg[sel_lvl] <= front_next;
                rear_reg[sel_lvl]  <= rear_next;
                occ_reg[sel_lvl]   <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= load_status;
            data_reg   <= load_data;
            level_reg  <= load_level;
        end
        if (go_read)
        begin
            pend_lvl_reg <= hi_lvl;
        end
    end

    mlpq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (data_in),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign level_out = level_reg;

`ifndef ASSERT_OFF
    a_deq_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && cmd == CMD_DEQ && (|occ_reg)) |=> state_reg == S_READ)
        else $error("dequeue of an occupied level did not start a ram read");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && rsp_free) |=> (rsp_valid_reg && status_reg == ST_OK))
        else $error("ram read did not produce an ok result");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg != ST_OK) |-> data_reg == 0)
        else $error("non-ok result carries data");

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_ptr_chk
        a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
            !occ_reg[g] |-> (front_reg[g] == 0 && rear_reg[g] == 0))
            else $error("empty level has nonzero pointers");

        a_front_rear: assert property (@(posedge clk) disable iff (!rst_n)
            occ_reg[g] |-> front_reg[g] <= rear_reg[g])
            else $error("front pointer passed rear pointer");
    end
`endif

endmodule
